### rtl/mpl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package mpl_pkg;

	// Field widths and fixed-point formats.
	localparam int PIX_W      = 24;
	localparam int ZOOM_W     = 5;
	localparam int TILE_LOG2  = 8;
	localparam int MAX_ZOOM   = 16;
	localparam int FRAC_BITS  = 28;
	localparam int GUARD_BITS = 4;
	localparam int WORK_BITS  = FRAC_BITS + GUARD_BITS;
	localparam int OUT_BITS   = FRAC_BITS + 3;
	localparam int DW         = 40;
	localparam int UFRAC_W    = 32;
	localparam int MAG_W      = 36;
	localparam int HALF_W     = MAG_W / 2;

	// Pipeline depths of the two rotators.
	localparam int HYP_STAGES  = 34;
	localparam int CIRC_STAGES = WORK_BITS + 1;

	typedef logic signed [DW-1:0] work_t;
	typedef work_t tab_t [0:WORK_BITS];

	// pi and 2pi with 60 fraction bits.
	localparam logic [63:0] PI_Q60     = 64'h3243F6A8885A308D;
	localparam logic [63:0] TWO_PI_Q60 = 64'h6487ED5110B4611A;
	localparam logic [31:0] TWO_PI_LO  = TWO_PI_Q60[31:0];
	localparam logic [30:0] TWO_PI_HI  = TWO_PI_Q60[62:32];

	localparam logic [63:0] PI_W64 = (PI_Q60 + 64'd134217728) >> 28;
	localparam work_t       PI_W   = PI_W64[DW-1:0];
	localparam logic [63:0] ONE64  = 64'd1 << WORK_BITS;
	localparam work_t       ONE_W  = ONE64[DW-1:0];

	// Restoring division, used only while building the constant tables.
	function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
		logic [64:0] rem;
		logic [63:0] quo;
		int          b;
		rem = '0;
		quo = '0;
		for (b = 63; b >= 0; b--) begin
			rem = {rem[63:0], num[b]};
			if (rem >= {1'b0, den}) begin
				rem = rem - {1'b0, den};
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	// Series of x^(2k+1)/(2k+1) with x = 2^-i in Q62, alternating for atan.
	function automatic logic [63:0] series_q62(input int i, input bit alternate);
		logic [63:0] p;
		logic [63:0] sum;
		logic [63:0] t;
		int          k;
		p   = 64'd1 << (62 - i);
		sum = '0;
		for (k = 0; k < 32; k++) begin
			if (p != 64'd0) begin
				t = udiv64(p, 64'(2 * k + 1));
				if (alternate && (k % 2 == 1)) begin
					sum = sum - t;
				end else begin
					sum = sum + t;
				end
				p = (2 * i >= 63) ? 64'd0 : (p >> (2 * i));
			end
		end
		return sum;
	endfunction

	// Angle tables in the work format: atan when alternate, else atanh.
	function automatic tab_t build_tab(input bit alternate);
		tab_t        tb;
		logic [63:0] w;
		int          i;
		w = (PI_Q60 + 64'd536870912) >> 30;
		tb[0] = alternate ? w[DW-1:0] : '0;
		for (i = 1; i <= WORK_BITS; i++) begin
			w = (series_q62(i, alternate) + 64'd536870912) >> 30;
			tb[i] = w[DW-1:0];
		end
		return tb;
	endfunction

	localparam tab_t ATAN_TAB  = build_tab(1'b1);
	localparam tab_t ATANH_TAB = build_tab(1'b0);

	// Shift of each hyperbolic stage; steps 4 and 13 are taken twice.
	function automatic int hyp_shift(input int j);
		if (j <= 3) begin
			return j + 1;
		end else if (j <= 13) begin
			return j;
		end
		return j - 1;
	endfunction

	// Shift right by s, rounding to nearest with ties away from zero.
	function automatic work_t round_shift(input work_t v, input int s);
		work_t mag;
		work_t half;
		half = work_t'(1) << (s - 1);
		mag  = v[DW-1] ? -v : v;
		mag  = (mag + half) >>> s;
		return v[DW-1] ? -mag : mag;
	endfunction

endpackage
`default_nettype wire

### rtl/mpl_hyp_cordic.sv
`timescale 1ns / 1ps
`default_nettype none
module mpl_hyp_cordic (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire logic           in_valid,
	input  mpl_pkg::work_t      z_in,
	output logic                out_valid,
	output mpl_pkg::work_t      x_out,
	output mpl_pkg::work_t      y_out
);

	localparam int N = mpl_pkg::HYP_STAGES;

	mpl_pkg::work_t hx_s [0:N-1];
	mpl_pkg::work_t hy_s [0:N-1];
	mpl_pkg::work_t hz_s [0:N-1];
	logic           hv_s [0:N-1];

	// One rotation step per register stage, starting from cosh = 1, sinh = 0.
	for (genvar g = 0; g < N; g++) begin : g_stage
		localparam int SH = mpl_pkg::hyp_shift(g);
		mpl_pkg::work_t xi, yi, zi;
		logic           vi;

		if (g == 0) begin : g_first
			assign xi = mpl_pkg::ONE_W;
			assign yi = '0;
			assign zi = z_in;
			assign vi = in_valid;
		end else begin : g_next
			assign xi = hx_s[g-1];
			assign yi = hy_s[g-1];
			assign zi = hz_s[g-1];
			assign vi = hv_s[g-1];
		end

		// Valid bit of the stage.
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				hv_s[g] <= 1'b0;
			end else if (en) begin
				hv_s[g] <= vi;
			end
		end

		// Direction follows the sign of the residual angle.
		always_ff @(posedge clk) begin
			if (en) begin
				if (!zi[mpl_pkg::DW-1]) begin
					hx_s[g] <= xi + (yi >>> SH);
					hy_s[g] <= yi + (xi >>> SH);
					hz_s[g] <= zi - mpl_pkg::ATANH_TAB[SH];
				end else begin
					hx_s[g] <= xi - (yi >>> SH);
					hy_s[g] <= yi - (xi >>> SH);
					hz_s[g] <= zi + mpl_pkg::ATANH_TAB[SH];
				end
			end
		end
	end

	assign out_valid = hv_s[N-1];
	assign x_out     = hx_s[N-1];
	assign y_out     = hy_s[N-1];

endmodule
`default_nettype wire

### rtl/mpl_circ_cordic.sv
`timescale 1ns / 1ps
`default_nettype none
module mpl_circ_cordic (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire logic           in_valid,
	input  mpl_pkg::work_t      x_in,
	input  mpl_pkg::work_t      y_in,
	output logic                out_valid,
	output mpl_pkg::work_t      z_out
);

	localparam int N = mpl_pkg::CIRC_STAGES;

	mpl_pkg::work_t cx_s [0:N-1];
	mpl_pkg::work_t cy_s [0:N-1];
	mpl_pkg::work_t cz_s [0:N-1];
	logic           cv_s [0:N-1];

	// Vectoring: drive y to zero and collect the angle, one step per stage.
	for (genvar g = 0; g < N; g++) begin : g_stage
		mpl_pkg::work_t xi, yi, zi;
		logic           vi;

		if (g == 0) begin : g_first
			assign xi = x_in;
			assign yi = y_in;
			assign zi = '0;
			assign vi = in_valid;
		end else begin : g_next
			assign xi = cx_s[g-1];
			assign yi = cy_s[g-1];
			assign zi = cz_s[g-1];
			assign vi = cv_s[g-1];
		end

		// Valid bit of the stage.
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cv_s[g] <= 1'b0;
			end else if (en) begin
				cv_s[g] <= vi;
			end
		end

		// Rotate towards the x axis.
		always_ff @(posedge clk) begin
			if (en) begin
				if (!yi[mpl_pkg::DW-1]) begin
					cx_s[g] <= xi + (yi >>> g);
					cy_s[g] <= yi - (xi >>> g);
					cz_s[g] <= zi + mpl_pkg::ATAN_TAB[g];
				end else begin
					cx_s[g] <= xi - (yi >>> g);
					cy_s[g] <= yi + (xi >>> g);
					cz_s[g] <= zi - mpl_pkg::ATAN_TAB[g];
				end
			end
		end
	end

	assign out_valid = cv_s[N-1];
	assign z_out     = cz_s[N-1];

endmodule
`default_nettype wire

### rtl/mercator_pixel_to_lonlat.sv
// One request is accepted per cycle unless the result register is held; most of the
// pipeline depth lies in the two CORDIC pipelines.
// A stalled result holds the whole pipeline, so nothing is lost or repeated.
// Reset (arst_n low) clears all valid bits and sets zoom_level to 0.
`timescale 1ns / 1ps
`default_nettype none
module mercator_pixel_to_lonlat (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [mpl_pkg::ZOOM_W-1:0]    cfg_wdata,
	input  wire logic                          pix_valid,
	output logic                               pix_stall,
	input  wire logic [mpl_pkg::PIX_W-1:0]     pixel_x,
	input  wire logic [mpl_pkg::PIX_W-1:0]     pixel_y,
	output logic                               res_valid,
	input  wire logic                          res_stall,
	output logic signed [mpl_pkg::OUT_BITS-1:0] lon_rad,
	output logic signed [mpl_pkg::OUT_BITS-1:0] lat_rad
);

	localparam int DW    = mpl_pkg::DW;
	localparam int HW    = mpl_pkg::HALF_W;
	localparam int DELAY = mpl_pkg::HYP_STAGES + 3 + mpl_pkg::CIRC_STAGES;

	logic                        en;
	logic [mpl_pkg::ZOOM_W-1:0]  zoom_level_q;

	// Zoom register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zoom_level_q <= '0;
		end else if (cfg_we) begin
			zoom_level_q <= cfg_wdata;
		end
	end

	// The whole pipeline advances unless the result register is held.
	assign en        = !(res_valid && res_stall);
	assign pix_stall = !en;

	// Stage 1: clamp to the map and form the 32-bit pixel fraction.
	logic [mpl_pkg::ZOOM_W-1:0] zq;
	logic [mpl_pkg::PIX_W:0]    edge_m1;
	logic [mpl_pkg::PIX_W-1:0]  pxc, pyc;
	logic [mpl_pkg::ZOOM_W-1:0] fsh;
	logic [31:0]                ux_s1, uy_s1;
	logic                       v_s1;

	always_comb begin
		zq = (zoom_level_q > mpl_pkg::ZOOM_W'(mpl_pkg::MAX_ZOOM)) ?
			mpl_pkg::ZOOM_W'(mpl_pkg::MAX_ZOOM) : zoom_level_q;
		edge_m1 = ((mpl_pkg::PIX_W+1)'(1) << (mpl_pkg::TILE_LOG2 + 32'(zq)))
			- (mpl_pkg::PIX_W+1)'(1);
		pxc = ({1'b0, pixel_x} > edge_m1) ? edge_m1[mpl_pkg::PIX_W-1:0] : pixel_x;
		pyc = ({1'b0, pixel_y} > edge_m1) ? edge_m1[mpl_pkg::PIX_W-1:0] : pixel_y;
		fsh = mpl_pkg::ZOOM_W'(mpl_pkg::UFRAC_W - mpl_pkg::TILE_LOG2) - zq;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= pix_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ux_s1 <= 32'(pxc) << fsh;
			uy_s1 <= 32'(pyc) << fsh;
		end
	end

	// Stage 2: partial products of the fraction with 2pi.
	logic [63:0] xlo_s2, ylo_s2;
	logic [62:0] xhi_s2, yhi_s2;
	logic        v_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xlo_s2 <= 64'(ux_s1) * 64'(mpl_pkg::TWO_PI_LO);
			ylo_s2 <= 64'(uy_s1) * 64'(mpl_pkg::TWO_PI_LO);
			xhi_s2 <= 63'(ux_s1) * 63'(mpl_pkg::TWO_PI_HI);
			yhi_s2 <= 63'(uy_s1) * 63'(mpl_pkg::TWO_PI_HI);
		end
	end

	// Stage 3: combine and round the angle into the work format.
	logic [64:0] tx, ty;
	logic [63:0] sx, sy;
	mpl_pkg::work_t ax_s3, ay_s3;
	logic           v_s3;

	always_comb begin
		tx = {1'b0, xlo_s2} + (65'd1 << 59);
		ty = {1'b0, ylo_s2} + (65'd1 << 59);
		sx = 64'(xhi_s2) + 64'(tx[64:32]);
		sy = 64'(yhi_s2) + 64'(ty[64:32]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s3 <= mpl_pkg::work_t'({4'b0, sx[63:28]});
			ay_s3 <= mpl_pkg::work_t'({4'b0, sy[63:28]});
		end
	end

	// Stage 4: move the angles to the range -pi to pi.
	mpl_pkg::work_t lonw_s4, sw_s4;
	logic           v_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lonw_s4 <= ax_s3 - mpl_pkg::PI_W;
			sw_s4   <= ay_s3 - mpl_pkg::PI_W;
		end
	end

	// Stage 5: round longitude to the output format, quarter the latitude angle.
	mpl_pkg::work_t lon_s5, z0_s5;
	logic           v_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lon_s5 <= mpl_pkg::round_shift(lonw_s4, mpl_pkg::GUARD_BITS);
			z0_s5  <= mpl_pkg::round_shift(sw_s4, 2);
		end
	end

	// Longitude waits alongside the latitude pipeline.
	logic [mpl_pkg::OUT_BITS-1:0] lon_dly_s [0:DELAY-1];

	always_ff @(posedge clk) begin
		if (en) begin
			lon_dly_s[0] <= lon_s5[mpl_pkg::OUT_BITS-1:0];
			for (int k = 1; k < DELAY; k++) begin
				lon_dly_s[k] <= lon_dly_s[k-1];
			end
		end
	end

	// Hyperbolic rotation gives scaled cosh and sinh of s/4.
	logic           hv;
	mpl_pkg::work_t hx, hy;

	mpl_hyp_cordic u_hyp (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s5),
		.z_in      (z0_s5),
		.out_valid (hv),
		.x_out     (hx),
		.y_out     (hy)
	);

	// Double-angle step, first stage: magnitudes split into halves and multiplied.
	logic [mpl_pkg::MAG_W-1:0] mx, my;
	logic [2*HW-1:0] xx_hh_s6, xx_hl_s6, xx_ll_s6;
	logic [2*HW-1:0] yy_hh_s6, yy_hl_s6, yy_ll_s6;
	logic [2*HW-1:0] xy_hh_s6, xy_hl_s6, xy_lh_s6, xy_ll_s6;
	logic            neg_s6, v_s6;
	mpl_pkg::work_t  ny;

	always_comb begin
		ny = -hy;
		mx = hx[mpl_pkg::MAG_W-1:0];
		my = hy[DW-1] ? ny[mpl_pkg::MAG_W-1:0] : hy[mpl_pkg::MAG_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= hv;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xx_hh_s6 <= (2*HW)'(mx[2*HW-1:HW]) * (2*HW)'(mx[2*HW-1:HW]);
			xx_hl_s6 <= (2*HW)'(mx[2*HW-1:HW]) * (2*HW)'(mx[HW-1:0]);
			xx_ll_s6 <= (2*HW)'(mx[HW-1:0]) * (2*HW)'(mx[HW-1:0]);
			yy_hh_s6 <= (2*HW)'(my[2*HW-1:HW]) * (2*HW)'(my[2*HW-1:HW]);
			yy_hl_s6 <= (2*HW)'(my[2*HW-1:HW]) * (2*HW)'(my[HW-1:0]);
			yy_ll_s6 <= (2*HW)'(my[HW-1:0]) * (2*HW)'(my[HW-1:0]);
			xy_hh_s6 <= (2*HW)'(mx[2*HW-1:HW]) * (2*HW)'(my[2*HW-1:HW]);
			xy_hl_s6 <= (2*HW)'(mx[2*HW-1:HW]) * (2*HW)'(my[HW-1:0]);
			xy_lh_s6 <= (2*HW)'(mx[HW-1:0]) * (2*HW)'(my[2*HW-1:HW]);
			xy_ll_s6 <= (2*HW)'(mx[HW-1:0]) * (2*HW)'(my[HW-1:0]);
			neg_s6   <= hy[DW-1];
		end
	end

	// Second stage: assemble the products and round them to the work format.
	localparam int PW = 4 * HW + 1;
	logic [PW-1:0] pxx, pyy, pxy;
	logic [DW-1:0] sxx_s7, syy_s7, sxy_s7;
	logic          neg_s7, v_s7;

	always_comb begin
		pxx = (PW'(xx_hh_s6) << (2*HW)) + (PW'(xx_hl_s6) << (HW+1)) + PW'(xx_ll_s6)
			+ (PW'(1) << (mpl_pkg::WORK_BITS - 1));
		pyy = (PW'(yy_hh_s6) << (2*HW)) + (PW'(yy_hl_s6) << (HW+1)) + PW'(yy_ll_s6)
			+ (PW'(1) << (mpl_pkg::WORK_BITS - 1));
		pxy = (PW'(xy_hh_s6) << (2*HW)) + ((PW'(xy_hl_s6) + PW'(xy_lh_s6)) << HW)
			+ PW'(xy_ll_s6) + (PW'(1) << (mpl_pkg::WORK_BITS - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sxx_s7 <= pxx[mpl_pkg::WORK_BITS +: DW];
			syy_s7 <= pyy[mpl_pkg::WORK_BITS +: DW];
			sxy_s7 <= pxy[mpl_pkg::WORK_BITS +: DW];
			neg_s7 <= neg_s6;
		end
	end

	// Third stage: cosh and sinh of s/2, up to the common gain.
	mpl_pkg::work_t bx_s8, by_s8;
	mpl_pkg::work_t sxy_sgn;
	logic           v_s8;

	assign sxy_sgn = neg_s7 ? -mpl_pkg::work_t'(sxy_s7) : mpl_pkg::work_t'(sxy_s7);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bx_s8 <= mpl_pkg::work_t'(sxx_s7) + mpl_pkg::work_t'(syy_s7);
			by_s8 <= sxy_sgn <<< 1;
		end
	end

	// Circular vectoring gives half the Gudermannian.
	logic           cv;
	mpl_pkg::work_t cz;

	mpl_circ_cordic u_circ (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s8),
		.x_in      (bx_s8),
		.y_in      (by_s8),
		.out_valid (cv),
		.z_out     (cz)
	);

	// Result register: latitude is minus twice the angle.
	mpl_pkg::work_t               latw;
	mpl_pkg::work_t               latr;
	logic [mpl_pkg::OUT_BITS-1:0] lon_q, lat_q;
	logic                         res_valid_q;

	always_comb begin
		latw = -(cz <<< 1);
		latr = mpl_pkg::round_shift(latw, mpl_pkg::GUARD_BITS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (en) begin
			res_valid_q <= cv;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lon_q <= lon_dly_s[DELAY-1];
			lat_q <= latr[mpl_pkg::OUT_BITS-1:0];
		end
	end

	assign res_valid = res_valid_q;
	assign lon_rad   = lon_q;
	assign lat_rad   = lat_q;

endmodule
`default_nettype wire

### rtl/mpl_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module mpl_checker (
	input wire logic                                  clk,
	input wire logic                                  arst_n,
	input wire logic                                  pix_stall,
	input wire logic                                  res_valid,
	input wire logic                                  res_stall,
	input wire logic signed [mpl_pkg::OUT_BITS-1:0]   lon_rad,
	input wire logic signed [mpl_pkg::OUT_BITS-1:0]   lat_rad
);

	localparam logic signed [mpl_pkg::OUT_BITS-1:0] PI_OUT = 31'sd843314857;

	// A held result keeps its value.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(lon_rad) && $stable(lat_rad))
		else $error("result changed while held");

	// Requests are refused exactly while the result is held.
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		pix_stall == (res_valid && res_stall))
		else $error("input stall does not follow output hold");

	// Longitude lies within plus and minus pi.
	a_lon: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (lon_rad >= -PI_OUT) && (lon_rad <= PI_OUT))
		else $error("longitude out of range");

	// Latitude lies within plus and minus pi.
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (lat_rad >= -PI_OUT) && (lat_rad <= PI_OUT))
		else $error("latitude out of range");

endmodule

bind mercator_pixel_to_lonlat mpl_checker u_mpl_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.pix_stall (pix_stall),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.lon_rad   (lon_rad),
	.lat_rad   (lat_rad)
);
`default_nettype wire

### verif/testbench.sv
`timescale 1ns / 1ps
module testbench;

	localparam logic [63:0] PI_Q60_C  = 64'h3243F6A8885A308D;
	localparam logic [63:0] TAU_Q60_C = 64'h6487ED5110B4611A;
	localparam int          WB        = 32;
	localparam int          SETTLE    = 90;

	typedef struct {
		logic [mpl_pkg::OUT_BITS-1:0] lon;
		logic [mpl_pkg::OUT_BITS-1:0] lat;
	} lonlat_t;

	typedef struct {
		logic [mpl_pkg::PIX_W-1:0]    px;
		logic [mpl_pkg::PIX_W-1:0]    py;
		bit                           lon_known;
		logic [mpl_pkg::OUT_BITS-1:0] lon;
	} pixel_row_t;

	logic                                clk;
	logic                                arst_n;
	logic                                cfg_we;
	logic [mpl_pkg::ZOOM_W-1:0]          cfg_wdata;
	logic                                pix_valid;
	logic                                pix_stall;
	logic [mpl_pkg::PIX_W-1:0]           pixel_x;
	logic [mpl_pkg::PIX_W-1:0]           pixel_y;
	logic                                res_valid;
	logic                                res_stall = 1'b0;
	logic signed [mpl_pkg::OUT_BITS-1:0] lon_rad;
	logic signed [mpl_pkg::OUT_BITS-1:0] lat_rad;

	mercator_pixel_to_lonlat dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.pix_valid(pix_valid), .pix_stall(pix_stall), .pixel_x(pixel_x),
		.pixel_y(pixel_y), .res_valid(res_valid), .res_stall(res_stall),
		.lon_rad(lon_rad), .lat_rad(lat_rad)
	);

	// Angle tables of the model rotators, in the 32-bit fraction work format.
	longint     circ_angle [0:WB];
	longint     hyp_angle [0:WB];
	logic [4:0] zoom_now;
	lonlat_t    coord_queue [$];
	int         fail_count;
	int         burst_left;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#50_000_000;
		$display("== FAIL ==");
		$finish;
	end

	// Builds one arctangent or area-tangent entry from its power series in Q62.
	function automatic longint angle_entry(input int i, input bit alternate);
		logic [63:0] term;
		logic [63:0] acc;
		logic [63:0] k;
		term = 64'd1 << (62 - i);
		acc  = '0;
		k    = '0;
		while (term != 64'd0) begin
			if (alternate && k[0]) begin
				acc = acc - term / (2 * k + 1);
			end else begin
				acc = acc + term / (2 * k + 1);
			end
			term = (2 * i >= 63) ? 64'd0 : (term >> (2 * i));
			k++;
		end
		return longint'((acc + (64'd1 << 29)) >> 30);
	endfunction

	// Shift with rounding to nearest, ties away from zero.
	function automatic longint shift_round(input longint v, input int s);
		longint half;
		half = longint'(1) << (s - 1);
		if (v >= 0) begin
			return (v + half) >>> s;
		end
		return -((-v + half) >>> s);
	endfunction

	// Signed product scaled down by the work fraction, magnitude rounded.
	function automatic longint scaled_mul(input longint a, input longint b);
		logic [127:0] prod;
		logic [63:0]  ua;
		logic [63:0]  ub;
		ua   = a < 0 ? -a : a;
		ub   = b < 0 ? -b : b;
		prod = ({64'd0, ua} * {64'd0, ub} + (128'd1 << (WB - 1))) >> WB;
		return ((a < 0) != (b < 0)) ? -longint'(prod[63:0]) : longint'(prod[63:0]);
	endfunction

	// Pixel position as an angle from zero to two pi.
	function automatic longint pixel_to_angle(input logic [63:0] p, input logic [63:0] n);
		logic [63:0]  frac;
		logic [127:0] prod;
		frac = (p << 32) / n;
		prod = ({64'd0, frac} * {64'd0, TAU_Q60_C} + (128'd1 << (59 - WB + 32))) >>
			(92 - WB);
		return longint'(prod[63:0]);
	endfunction

	// Half the Gudermannian: hyperbolic rotation of s/4, then circular vectoring.
	function automatic longint half_gudermann(input longint s);
		longint x;
		longint y;
		longint z;
		longint dx;
		longint dy;
		longint bx;
		longint by;
		int     i;
		int     pass;
		int     passes;
		int     rep;
		x   = longint'(1) << WB;
		y   = 0;
		z   = shift_round(s, 2);
		rep = 4;
		for (i = 1; i <= WB; i++) begin
			passes = 1;
			if (i == rep) begin
				passes = 2;
				rep    = 3 * rep + 1;
			end
			for (pass = 0; pass < passes; pass++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (z >= 0) begin
					x = x + dx; y = y + dy; z = z - hyp_angle[i];
				end else begin
					x = x - dx; y = y - dy; z = z + hyp_angle[i];
				end
			end
		end
		bx = scaled_mul(x, x) + scaled_mul(y, y);
		by = 2 * scaled_mul(x, y);
		z  = 0;
		for (i = 0; i <= WB; i++) begin
			dx = by >>> i;
			dy = bx >>> i;
			if (by >= 0) begin
				bx = bx + dx; by = by - dy; z = z + circ_angle[i];
			end else begin
				bx = bx - dx; by = by + dy; z = z - circ_angle[i];
			end
		end
		return z;
	endfunction

	function automatic lonlat_t project_pixel(input logic [mpl_pkg::PIX_W-1:0] px,
			input logic [mpl_pkg::PIX_W-1:0] py, input logic [4:0] zoom);
		lonlat_t     r;
		logic [63:0] n;
		logic [63:0] cx;
		logic [63:0] cy;
		longint      pi_w;
		longint      lon_w;
		longint      lat_w;
		n     = 64'd256 << ((zoom > 16) ? 16 : zoom);
		cx    = (px >= n) ? n - 1 : px;
		cy    = (py >= n) ? n - 1 : py;
		pi_w  = longint'((PI_Q60_C + (64'd1 << 27)) >> 28);
		lon_w = pixel_to_angle(cx, n) - pi_w;
		lat_w = -2 * half_gudermann(pixel_to_angle(cy, n) - pi_w);
		r.lon = mpl_pkg::OUT_BITS'(shift_round(lon_w, 4));
		r.lat = mpl_pkg::OUT_BITS'(shift_round(lat_w, 4));
		return r;
	endfunction

	// Hands one pixel request over and queues its expected coordinates.
	task automatic send_pixel(input logic [mpl_pkg::PIX_W-1:0] px,
			input logic [mpl_pkg::PIX_W-1:0] py,
			input bit lon_known, input logic [mpl_pkg::OUT_BITS-1:0] lon);
		lonlat_t exp_c;
		bit      took;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			if ($urandom_range(0, 2) != 0) begin
				pix_valid <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
		burst_left--;
		pix_valid <= 1'b1;
		pixel_x   <= px;
		pixel_y   <= py;
		do begin
			@(negedge clk);
			took = !pix_stall;
			@(posedge clk);
		end while (!took);
		exp_c = project_pixel(px, py, zoom_now);
		if (lon_known && exp_c.lon != lon) begin
			$error("lon_rad table: expected %0d, model gives %0d", $signed(lon),
				$signed(exp_c.lon));
			fail_count++;
			exp_c.lon = lon;
		end
		coord_queue.push_back(exp_c);
	endtask

	// Waits for the pipeline to drain, then writes the zoom level.
	task automatic set_zoom(input logic [4:0] z);
		pix_valid <= 1'b0;
		@(posedge clk);
		while (coord_queue.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= z;
		@(posedge clk);
		cfg_we    <= 1'b0;
		zoom_now = z;
	endtask

	// Receiver stall pattern: runs of free flow, light and heavy stalling.
	int stall_mode = 0;
	int stall_run = 0;
	always @(posedge clk) begin
		if (stall_run == 0) begin
			stall_mode = $urandom_range(0, 2);
			stall_run  = $urandom_range(5, 60);
		end
		stall_run--;
		case (stall_mode)
			0: res_stall <= 1'b0;
			1: res_stall <= ($urandom_range(0, 3) == 0);
			default: res_stall <= ($urandom_range(0, 3) != 0);
		endcase
	end

	// Result checker against the oldest outstanding expectation.
	always @(posedge clk) begin
		lonlat_t exp_c;
		if (arst_n && res_valid && !res_stall) begin
			if (coord_queue.size() == 0) begin
				$error("result with no request outstanding: lon %0d lat %0d", lon_rad,
					lat_rad);
				fail_count++;
			end else begin
				exp_c = coord_queue.pop_front();
				if (lon_rad !== exp_c.lon) begin
					$error("lon_rad: expected %0d, got %0d", $signed(exp_c.lon), lon_rad);
					fail_count++;
				end
				if (lat_rad !== exp_c.lat) begin
					$error("lat_rad: expected %0d, got %0d", $signed(exp_c.lat), lat_rad);
					fail_count++;
				end
			end
		end
	end

	pixel_row_t pixel_table [] = '{
		'{24'd0,        24'd0,        1'b0, 31'd0},
		'{24'd128,      24'd128,      1'b1, 31'd0},
		'{24'd255,      24'd255,      1'b0, 31'd0},
		'{24'd256,      24'd0,        1'b0, 31'd0},
		'{24'hFFFFFF,   24'hFFFFFF,   1'b0, 31'd0},
		'{24'd0,        24'hFFFFFF,   1'b0, 31'd0},
		'{24'd128,      24'd0,        1'b1, 31'd0},
		'{24'd1,        24'd254,      1'b0, 31'd0},
		'{24'd127,      24'd129,      1'b0, 31'd0},
		'{24'd64,       24'd192,      1'b0, 31'd0},
		'{24'hAAAAAA,   24'h555555,   1'b0, 31'd0},
		'{24'd128,      24'd1,        1'b1, 31'd0}
	};

	initial begin
		int          ph;
		int          k;
		int          lim;
		logic [23:0] rx;
		logic [23:0] ry;
		logic [63:0] n;
		logic [4:0]  zooms [8] = '{5'd16, 5'd0, 5'd31, 5'd17, 5'd5, 5'd1, 5'd10, 5'd8};
		arst_n     = 1'b0;
		cfg_we     = 1'b0;
		cfg_wdata  = '0;
		pix_valid  = 1'b0;
		pixel_x    = '0;
		pixel_y    = '0;
		burst_left = 0;
		fail_count = 0;
		zoom_now   = 5'd0;
		circ_angle[0] = longint'((PI_Q60_C + (64'd1 << 29)) >> 30);
		hyp_angle[0]  = 0;
		for (k = 1; k <= WB; k++) begin
			circ_angle[k] = angle_entry(k, 1'b1);
			hyp_angle[k]  = angle_entry(k, 1'b0);
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows at the reset zoom level.
		foreach (pixel_table[i]) begin
			send_pixel(pixel_table[i].px, pixel_table[i].py, pixel_table[i].lon_known,
				pixel_table[i].lon);
		end

		// Random phases, one per zoom setting; each starts from an empty pipeline.
		for (ph = 0; ph < 8; ph++) begin
			set_zoom(ph == 7 ? 5'($urandom_range(0, 31)) : zooms[ph]);
			n = 64'd256 << ((zoom_now > 16) ? 16 : zoom_now);
			for (k = 0; k < 142; k++) begin
				case ($urandom_range(0, 5))
					0: begin
						rx = 24'($urandom);
						ry = 24'($urandom);
					end
					1: begin
						rx = 24'(n - 1 - $urandom_range(0, 3));
						ry = 24'($urandom_range(0, 3));
					end
					2: begin
						rx = 24'(n / 2 + $urandom_range(0, 2) - 1);
						ry = 24'(n / 2 + $urandom_range(0, 2) - 1);
					end
					default: begin
						rx = 24'($urandom % n);
						ry = 24'($urandom % n);
					end
				endcase
				send_pixel(rx, ry, 1'b0, '0);
			end
		end

		pix_valid <= 1'b0;
		lim = 0;
		while (coord_queue.size() != 0 && lim < 100_000) begin
			@(posedge clk);
			lim++;
		end
		repeat (SETTLE) @(posedge clk);
		if (coord_queue.size() != 0) begin
			$error("%0d results never arrived", coord_queue.size());
			fail_count++;
		end
		if (fail_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
